[rtl/trimmed_moving_average_scale_assert.svh]
// assertion macros for the trimmed moving average scale block
// no dependencies; include once per file that checks its own logic
`ifndef TRIMMED_MOVING_AVERAGE_SCALE_ASSERT_SVH
`define TRIMMED_MOVING_AVERAGE_SCALE_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define TMAS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmas: assertion failed");
// checked at every edge, reset included
`define TMAS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("tmas: assertion failed");
`else
`define TMAS_ASSERT(lbl, clk, rst_n, prop)
`define TMAS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/tmas_pkg.sv]
// shared types and constants for the trimmed moving average scale block
// no dependencies
package tmas_pkg;

    // field widths
    localparam int SAMPLE_W      = 24;
    localparam int VALUE_W       = 32;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int FRAC_W        = 24;
    localparam int PROD_W        = 2 * CFG_W;
    localparam int WIN_DEPTH_DEF = 16;

    localparam logic [CFG_W-1:0] GAIN_RESET = 32'h0100_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RECIP  = 2'd2;

    // window sequencer
    typedef enum logic [2:0] {
        W_CLEAR,
        W_IDLE,
        W_READ,
        W_SCAN,
        W_LAST,
        W_DONE
    } t_win_state;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } t_top_state;

    // window status toward the top level
    typedef struct packed {
        logic ready;
        logic done;
    } t_win_stat;

endpackage

[rtl/tmas_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tmas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/tmas_window.sv]
// sample window: ram, running sum, oldest pointer and max/min scan
// depends on tmas_pkg and tmas_ram
module tmas_window import tmas_pkg::*; #(
    parameter int WINDOW_DEPTH = WIN_DEPTH_DEF,
    localparam int AW = $clog2(WINDOW_DEPTH),
    localparam int SW = SAMPLE_W + AW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SAMPLE_W-1:0]  i_sample,
    output t_win_stat            o_stat,
    output logic signed [SW-1:0] o_trim_sum
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    t_win_state r_state, n_state;
    logic [AW-1:0] r_ptr, r_clr_addr, r_scan_addr;
    logic signed [SW-1:0] r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_hi, r_lo;
    logic r_rd_vld, r_rd_first;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [SAMPLE_W-1:0] ram_wr_data, ram_rd_data;
    logic signed [SAMPLE_W-1:0] rd_s;

    assign rd_s = $signed(ram_rd_data);

    tmas_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            W_CLEAR: if (r_clr_addr == LAST_ADDR) n_state = W_IDLE;
            W_IDLE:  if (i_start) n_state = W_READ;
            W_READ:  n_state = W_SCAN;
            W_SCAN:  if (r_scan_addr == LAST_ADDR) n_state = W_LAST;
            W_LAST:  n_state = W_DONE;
            W_DONE:  n_state = W_IDLE;
            default: n_state = W_CLEAR;
        endcase
    end

    // ram controls and status
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_ptr;
        ram_wr_data = r_sample;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_ptr;
        o_stat      = '0;
        case (r_state)
            W_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = '0;
            end
            W_IDLE: begin
                ram_rd_en    = i_start;
                o_stat.ready = 1'b1;
            end
            W_READ: begin
                ram_wr_en = 1'b1;
            end
            W_SCAN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_scan_addr;
            end
            W_DONE: begin
                o_stat.done = 1'b1;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= W_CLEAR;
            r_ptr      <= '0;
            r_clr_addr <= '0;
            r_sum      <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == W_SCAN);
            if (r_state == W_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // drop the oldest, add the newest, advance the pointer
            if (r_state == W_READ) begin
                r_sum <= r_sum - SW'(rd_s) + SW'($signed(r_sample));
                r_ptr <= (r_ptr == LAST_ADDR) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    // scan address, sample and extremes
    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_scan_addr == '0);
        if (r_state == W_READ) begin
            r_scan_addr <= '0;
        end else if (r_state == W_SCAN) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
        if (r_state == W_IDLE && i_start) begin
            r_sample <= i_sample;
        end
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_hi <= rd_s;
                r_lo <= rd_s;
            end else begin
                if (rd_s > r_hi) r_hi <= rd_s;
                if (rd_s < r_lo) r_lo <= rd_s;
            end
        end
    end

    // sum less the extremes
    assign o_trim_sum = r_sum - SW'(r_hi) - SW'(r_lo);

endmodule

[rtl/tmas_div.sv]
// divider of the trimmed sum by depth minus two, truncating toward zero
// reciprocal multiply, registered magnitude then registered quotient; depends on tmas_pkg
module tmas_div import tmas_pkg::*; #(
    parameter int WINDOW_DEPTH = WIN_DEPTH_DEF,
    localparam int AW = $clog2(WINDOW_DEPTH),
    localparam int SW = SAMPLE_W + AW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SW-1:0]       i_dividend,
    output logic                       o_done,
    output logic signed [SAMPLE_W-1:0] o_quot
);

    // magnitude stays below 2^MAG_W; a reciprocal rounded up with
    // MAG_W + clog2(divisor) fraction bits is exact over that range
    localparam int MAG_W   = SW - 1;
    localparam int DIVISOR = WINDOW_DEPTH - 2;
    localparam int SHIFT   = MAG_W + $clog2(DIVISOR);
    localparam int RECIP_W = MAG_W + 1;
    localparam int QPROD_W = MAG_W + RECIP_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

    logic [1:0]          r_vld;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [SAMPLE_W-1:0] r_quo;
    logic [MAG_W-1:0]    mag;
    logic [QPROD_W-1:0]  prod;

    // magnitude of the dividend
    assign mag = i_dividend[SW-1] ? MAG_W'(-i_dividend) : MAG_W'(i_dividend);

    // multiply by the reciprocal, keep the integer part
    assign prod = QPROD_W'(r_mag) * QPROD_W'(RECIP);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], i_start};
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_mag <= mag;
        end
        if (r_vld[0]) begin
            r_quo <= prod[SHIFT +: SAMPLE_W];
        end
    end

    assign o_done = r_vld[1];
    assign o_quot = r_neg ? $signed(SAMPLE_W'(-r_quo)) : $signed(r_quo);

endmodule

[rtl/tmas_scale.sv]
// offset, gain multiply and saturation of the trimmed mean, or its raw pass-through
// depends on tmas_pkg
module tmas_scale import tmas_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SAMPLE_W-1:0] i_mean,
    input  logic                       i_raw_mode,
    input  logic signed [CFG_W-1:0]    i_zero_offset,
    input  logic [CFG_W-1:0]           i_gain_recip,
    output logic                       o_done,
    output logic signed [VALUE_W-1:0]  o_value
);

    localparam int HI_W = PROD_W - FRAC_W;
    localparam logic [HI_W-1:0] POS_LIMIT = HI_W'(32'h7fff_ffff);

    logic [2:0]                 r_vld;
    logic                       r_neg;
    logic [CFG_W-1:0]           r_mag;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [PROD_W-1:0]          r_prod;
    logic signed [VALUE_W-1:0]  r_value;

    logic signed [CFG_W:0] diff;
    logic [CFG_W:0]        diff_abs;
    logic [HI_W-1:0]       prod_hi;
    logic signed [VALUE_W-1:0] n_value;

    // mean less offset, split into sign and magnitude
    assign diff     = (CFG_W + 1)'(i_mean) - (CFG_W + 1)'(i_zero_offset);
    assign diff_abs = diff[CFG_W] ? (CFG_W + 1)'(-diff) : diff;

    // drop the fraction and saturate, or pass the mean through in raw mode
    assign prod_hi = r_prod[PROD_W-1:FRAC_W];
    always_comb begin
        if (i_raw_mode) begin
            n_value = VALUE_W'(r_mean);
        end else if (r_neg) begin
            if (prod_hi > POS_LIMIT) begin
                n_value = $signed({1'b1, {(VALUE_W-1){1'b0}}});
            end else begin
                n_value = $signed(VALUE_W'(-prod_hi[VALUE_W-1:0]));
            end
        end else if (prod_hi > POS_LIMIT) begin
            n_value = $signed({1'b0, {(VALUE_W-1){1'b1}}});
        end else begin
            n_value = $signed(prod_hi[VALUE_W-1:0]);
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= diff[CFG_W];
            r_mag  <= diff_abs[CFG_W-1:0];
            r_mean <= i_mean;
        end
        if (r_vld[0]) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(i_gain_recip);
        end
        if (r_vld[1]) begin
            r_value <= n_value;
        end
    end

    assign o_done  = r_vld[2];
    assign o_value = r_value;

endmodule

[rtl/trimmed_moving_average_scale.sv]
// flow: an input beat passes through the ram update and the max/min scan,
//   then the divide and then the scale before reaching the output register
// input: a new beat is taken only once the previous result is in the output
//   register; a stalled output beat holds the sequencer until it is taken
// reset: synchronous, active low; the window ram is then cleared,
//   during which o_stall stays high
`include "trimmed_moving_average_scale_assert.svh"
module trimmed_moving_average_scale import tmas_pkg::*; #(
    parameter int WINDOW_DEPTH = WIN_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [SAMPLE_W-1:0]        i_raw_code,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_trimmed_mean,
    output logic signed [VALUE_W-1:0]  o_value
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int SW = SAMPLE_W + AW;

    t_top_state r_state, n_state;

    logic                       r_raw_mode;
    logic signed [CFG_W-1:0]    r_zero_offset;
    logic [CFG_W-1:0]           r_gain_recip;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_mean;
    logic signed [VALUE_W-1:0]  r_out_value;

    t_win_stat                  win_stat;
    logic signed [SW-1:0]       trim_sum;
    logic                       div_done, scale_done;
    logic signed [SAMPLE_W-1:0] div_quot;
    logic signed [VALUE_W-1:0]  scale_value;
    logic in_accept, win_start, div_start, scale_start, out_load, out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode    <= 1'b0;
            r_zero_offset <= '0;
            r_gain_recip  <= GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RAW_MODE:    r_raw_mode    <= i_cfg_data[0];
                CFG_ZERO_OFFSET: r_zero_offset <= $signed(i_cfg_data);
                CFG_GAIN_RECIP:  r_gain_recip  <= i_cfg_data;
                default:         r_raw_mode    <= r_raw_mode;
            endcase
        end
    end

    tmas_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (win_start),
        .i_sample   (i_raw_code),
        .o_stat     (win_stat),
        .o_trim_sum (trim_sum)
    );

    tmas_div #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (trim_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    tmas_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (scale_start),
        .i_mean        (div_quot),
        .i_raw_mode    (r_raw_mode),
        .i_zero_offset (r_zero_offset),
        .i_gain_recip  (r_gain_recip),
        .o_done        (scale_done),
        .o_value       (scale_value)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign in_accept = i_valid && !o_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_accept) n_state = ST_WIN;
            ST_WIN:   if (win_stat.done) n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_SCALE;
            ST_SCALE: if (scale_done) n_state = out_free ? ST_IDLE : ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall     = 1'b1;
        win_start   = 1'b0;
        div_start   = 1'b0;
        scale_start = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall   = !win_stat.ready;
                win_start = i_valid && win_stat.ready;
            end
            ST_WIN:   div_start   = win_stat.done;
            ST_DIV:   scale_start = div_done;
            ST_SCALE: out_load    = scale_done && out_free;
            ST_OUT:   out_load    = out_free;
            default:  o_stall     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean  <= div_quot;
            r_out_value <= scale_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_trimmed_mean = r_out_mean;
    assign o_value        = r_out_value;

    // checks
    `TMAS_ASSERT_ALWAYS(a_stall_after_reset, i_clk, !i_rst_n |=> o_stall)
    `TMAS_ASSERT(a_accept_starts_window, i_clk, i_rst_n, in_accept |=> (r_state == ST_WIN))
    `TMAS_ASSERT(a_load_only_when_free, i_clk, i_rst_n, out_load |-> out_free)
    `TMAS_ASSERT(a_div_done_in_div, i_clk, i_rst_n, div_done |-> (r_state == ST_DIV))
    `TMAS_ASSERT(a_scale_done_in_scale, i_clk, i_rst_n, scale_done |-> (r_state == ST_SCALE))

endmodule

[bench/tb_trimmed_moving_average_scale.sv]
// testbench for the trimmed moving average scale block: random and directed converter codes
// checked against an in-bench window predictor; depends on tmas_pkg and the block's rtl
module tb_trimmed_moving_average_scale;
    import tmas_pkg::*;

    localparam int WIN_DEPTH     = WIN_DEPTH_DEF;
    localparam int SETTLE_CYCLES = WIN_DEPTH + 44;
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_LEN      = 400;
    localparam int PHASE_ITEMS   = 230;
    localparam int IDLE_PCT      = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [SAMPLE_W-1:0] CODE_POS_MAX = 24'h7f_ffff;
    localparam logic [SAMPLE_W-1:0] CODE_NEG_MAX = 24'h80_0000;
    localparam logic [SAMPLE_W-1:0] CODE_NEG_ONE = 24'hff_ffff;
    localparam logic [SAMPLE_W-1:0] CODE_ZERO    = 24'h00_0000;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [VALUE_W-1:0]  value;
    } t_reading;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data  = '0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic [SAMPLE_W-1:0]        i_raw_code  = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic signed [SAMPLE_W-1:0] o_trimmed_mean;
    logic signed [VALUE_W-1:0]  o_value;

    trimmed_moving_average_scale i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_code     (i_raw_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_trimmed_mean (o_trimmed_mean),
        .o_value        (o_value)
    );

    wire in_beat  = i_valid && !o_stall;
    wire out_beat = o_valid && !i_stall;

    // bench copy of the window and the registers
    logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
    logic signed [27:0]         win_sum     = '0;
    int                         oldest_slot = 0;
    logic                       cfg_raw     = 1'b0;
    logic signed [CFG_W-1:0]    cfg_offset  = '0;
    logic [CFG_W-1:0]           cfg_gain    = GAIN_RESET;

    logic [SAMPLE_W-1:0] pending_codes [$];
    t_reading            expected_readings [$];
    t_reading            next_reading;
    int                  codes_taken = 0;
    int                  mismatches  = 0;
    int                  quiet_cycles = 0;
    int                  hold_left   = 0;
    logic                hold_used   = 1'b0;
    logic                calm        = 1'b0;

    initial begin
        for (int k = 0; k < WIN_DEPTH; k++) win_mem[k] = '0;
    end

    // push one code into the window and work out the reading it gives
    function automatic t_reading advance_window(input logic [SAMPLE_W-1:0] code);
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
        longint                     mean_q;
        longint                     diff_q;
        logic [63:0]                mag;
        logic [63:0]                prod;
        t_reading                   r;
        win_sum = win_sum - win_mem[oldest_slot] + $signed(code);
        win_mem[oldest_slot] = $signed(code);
        oldest_slot = (oldest_slot == WIN_DEPTH - 1) ? 0 : oldest_slot + 1;
        hi = win_mem[0];
        lo = win_mem[0];
        for (int k = 1; k < WIN_DEPTH; k++) begin
            if (win_mem[k] > hi) hi = win_mem[k];
            if (win_mem[k] < lo) lo = win_mem[k];
        end
        mean_q = (longint'(win_sum) - longint'(hi) - longint'(lo)) / (WIN_DEPTH - 2);
        r.mean = mean_q[SAMPLE_W-1:0];
        if (cfg_raw) begin
            r.value = 32'(mean_q);
        end else begin
            diff_q = mean_q - longint'(cfg_offset);
            mag = (diff_q < 0) ? 64'(-diff_q) : 64'(diff_q);
            prod = (mag * 64'(cfg_gain)) >> FRAC_W;
            if (diff_q < 0) begin
                r.value = (prod >= 64'h8000_0000) ? VALUE_MIN : -prod[VALUE_W-1:0];
            end else begin
                r.value = (prod > 64'h7fff_ffff) ? VALUE_MAX : prod[VALUE_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers queued codes, predicts each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                expected_readings.push_back(advance_window(i_raw_code));
                codes_taken <= codes_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_codes.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    i_valid    <= 1'b1;
                    i_raw_code <= pending_codes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat, drives the stall with random hold-offs and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (out_beat) begin
                if (expected_readings.size() == 0) begin
                    flag_error($sformatf("result beat with nothing expected: mean %0d value %0d",
                                         o_trimmed_mean, o_value));
                end else begin
                    next_reading = expected_readings.pop_front();
                    if (o_trimmed_mean !== next_reading.mean)
                        flag_error($sformatf("trimmed_mean got %0d want %0d",
                                             o_trimmed_mean, next_reading.mean));
                    if (o_value !== next_reading.value)
                        flag_error($sformatf("value got %0d want %0d",
                                             o_value, next_reading.value));
                end
            end
            if (!hold_used && codes_taken >= HOLD_AT) begin
                hold_used <= 1'b1;
                hold_left <= HOLD_LEN;
                i_stall   <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || in_beat || out_beat) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // wait until every queued code went through and every reading came back
    task automatic drain();
        @(negedge i_clk);
        while (pending_codes.size() != 0 || i_valid || expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            CFG_RAW_MODE:    cfg_raw    = data[0];
            CFG_ZERO_OFFSET: cfg_offset = data;
            CFG_GAIN_RECIP:  cfg_gain   = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // half noise around a load level, with full-range, extreme and near-zero codes mixed in
    task automatic queue_random(input int count, input logic [SAMPLE_W-1:0] level);
        int                  pick;
        int                  noise;
        logic [SAMPLE_W-1:0] code;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                noise = $urandom_range(511) - 256;
                code  = level + SAMPLE_W'(noise);
            end else if (pick < 80) begin
                code = SAMPLE_W'($urandom);
            end else if (pick < 90) begin
                case ($urandom_range(3))
                    0: code = CODE_POS_MAX;
                    1: code = CODE_NEG_MAX;
                    2: code = CODE_NEG_ONE;
                    default: code = CODE_ZERO;
                endcase
            end else begin
                noise = $urandom_range(63) - 32;
                code  = SAMPLE_W'(noise);
            end
            pending_codes.push_back(code);
        end
    endtask

    // reset, directed codes, then register settings phase by phase
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start-up fill with reset registers: extremes, bit patterns, then runs of the two extremes
        pending_codes.push_back(CODE_POS_MAX);
        pending_codes.push_back(CODE_NEG_MAX);
        pending_codes.push_back(CODE_NEG_ONE);
        pending_codes.push_back(24'h00_0001);
        pending_codes.push_back(CODE_ZERO);
        pending_codes.push_back(24'haa_aaaa);
        pending_codes.push_back(24'h55_5555);
        repeat (9) pending_codes.push_back(CODE_POS_MAX);
        repeat (4) pending_codes.push_back(CODE_NEG_MAX);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    // raw mode, other registers should not matter
                    set_reg(CFG_RAW_MODE, $urandom | 32'd1);
                    set_reg(CFG_ZERO_OFFSET, $urandom);
                    set_reg(CFG_GAIN_RECIP, $urandom);
                end
                1: begin
                    // write to an unknown index is ignored
                    set_reg(CFG_UNUSED, $urandom);
                end
                2: begin
                    // zero gain, run without any idling
                    set_reg(CFG_RAW_MODE, $urandom & ~32'd1);
                    set_reg(CFG_ZERO_OFFSET, '0);
                    set_reg(CFG_GAIN_RECIP, '0);
                    calm = 1'b1;
                end
                3: begin
                    // saturation toward the negative limit
                    set_reg(CFG_ZERO_OFFSET, VALUE_MAX);
                    set_reg(CFG_GAIN_RECIP, 32'hffff_ffff);
                end
                4: begin
                    // saturation toward the positive limit
                    set_reg(CFG_ZERO_OFFSET, VALUE_MIN);
                end
                5: begin
                    set_reg(CFG_ZERO_OFFSET, $urandom);
                    set_reg(CFG_GAIN_RECIP, $urandom);
                end
                6: begin
                    // realistic scale: offset within the converter range, gain at most 4.0
                    set_reg(CFG_ZERO_OFFSET, 32'($signed(SAMPLE_W'($urandom))));
                    set_reg(CFG_GAIN_RECIP, $urandom_range(32'h0400_0000, 1));
                end
                default: begin
                    // smallest nonzero gain
                    set_reg(CFG_ZERO_OFFSET, 32'($signed(SAMPLE_W'($urandom))));
                    set_reg(CFG_GAIN_RECIP, 32'h0000_0001);
                end
            endcase
            queue_random(PHASE_ITEMS, SAMPLE_W'($urandom));
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
